// ===== hdl/salc_pkg.sv =====
package salc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_COUNT_BITS   = 32;

    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int CNT_OUT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [2:0] RST_SET_BITS   = 3'd4;
    localparam logic [3:0] RST_WAYS       = 4'd1;
    localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways_in_use;
        logic [5:0] block_bits;
    } t_cfg;

endpackage

// ===== hdl/salc_front.sv =====
module salc_front import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [ADDR_W-1:0] i_address,
    output logic              o_q_vld,
    input  logic              i_q_pop,
    output logic [1:0]        o_q_mode,
    output logic [TAG_W-1:0]  o_q_tag,
    output logic [SET_W-1:0]  o_q_set
);

    logic [3:0]        s_eff;
    logic [6:0]        shamt;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] set_full;
    logic [SET_W-1:0]  set_idx;
    logic              push;

    logic [1:0]       r_q_mode [2];
    logic [TAG_W-1:0] r_q_tag  [2];
    logic [SET_W-1:0] r_q_set  [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_cnt;

    always_comb begin
        if ({1'b0, i_cfg.set_bits} > 4'(MAX_SET_BITS)) begin
            s_eff = 4'(MAX_SET_BITS);
        end else begin
            s_eff = {1'b0, i_cfg.set_bits};
        end
        shamt    = 7'(s_eff) + 7'(i_cfg.block_bits);
        tag      = (shamt < 7'd64) ? (i_address >> shamt) : '0;
        set_full = i_address >> i_cfg.block_bits;
        set_idx  = set_full[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
    end

    assign o_ready  = (r_cnt != 2'd2);
    assign push     = i_valid && o_ready;
    assign o_q_vld  = (r_cnt != 2'd0);
    assign o_q_mode = r_q_mode[r_rd_ptr];
    assign o_q_tag  = r_q_tag[r_rd_ptr];
    assign o_q_set  = r_q_set[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mode[r_wr_ptr] <= i_mode;
            r_q_tag[r_wr_ptr]  <= tag;
            r_q_set[r_wr_ptr]  <= set_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/salc_back.sv =====
module salc_back import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_vld,
    output logic                  o_q_pop,
    input  logic [1:0]            i_q_mode,
    input  logic [TAG_W-1:0]      i_q_tag,
    input  logic [SET_W-1:0]      i_q_set,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_outcome,
    output logic                  o_store_hit,
    output logic [COUNT_BITS-1:0] o_hits,
    output logic [COUNT_BITS-1:0] o_misses,
    output logic [COUNT_BITS-1:0] o_evicts
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam logic [RANK_W-1:0]     RANK_MAX = RANK_W'(MAX_WAYS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CMP  = 1'b1;

    logic [MAX_WAYS-1:0][TAG_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [MAX_WAYS-1:0][RANK_W-1:0] r_rank_mem [NUM_SETS];
    logic [FILL_W-1:0]               r_fill_mem [NUM_SETS];
    logic [NUM_SETS-1:0]             r_set_vld;

    logic [MAX_WAYS-1:0][TAG_W-1:0]  r_tag_rd;
    logic [MAX_WAYS-1:0][RANK_W-1:0] r_rank_rd;
    logic [FILL_W-1:0]               r_fill_rd;
    logic                            r_vld_rd;

    logic             r_state;
    logic [1:0]       r_cur_mode;
    logic [TAG_W-1:0] r_cur_tag;
    logic [SET_W-1:0] r_cur_set;

    logic                  r_out_vld;
    logic [1:0]            r_outcome;
    logic                  r_store_hit;
    logic [COUNT_BITS-1:0] r_hits, r_misses, r_evicts;

    logic                            commit;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  n_tags;
    logic [MAX_WAYS-1:0][RANK_W-1:0] n_ranks;
    logic [FILL_W-1:0]               n_fill;
    logic [1:0]                      n_outcome;
    logic [COUNT_BITS-1:0]           n_hits, n_misses, n_evicts;

    assign o_q_pop = (r_state == S_IDLE) && i_q_vld;
    assign commit  = (r_state == S_CMP) && (!r_out_vld || i_ready);

    always_comb begin
        logic [4:0]            w5;
        logic [FILL_W-1:0]     fill, e, n;
        logic                  hit, free, modify;
        logic [WAY_W-1:0]      hit_way, victim, tgt;
        logic [RANK_W-1:0]     tgt_rank;
        logic [1:0]            hit_amt;
        logic [COUNT_BITS:0]   hsum;

        fill = r_vld_rd ? r_fill_rd : '0;
        w5 = {1'b0, i_cfg.ways_in_use};
        if (w5 == 5'd0) begin
            w5 = 5'd1;
        end
        if (w5 > 5'(MAX_WAYS)) begin
            w5 = 5'(MAX_WAYS);
        end
        e    = FILL_W'(w5);
        n    = (fill < e) ? fill : e;
        free = (fill < e);

        hit     = 1'b0;
        hit_way = '0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (!hit && (n > FILL_W'(k)) && (r_tag_rd[k] == r_cur_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(k);
            end
        end

        victim = '0;
        for (int k = 1; k < MAX_WAYS; k++) begin
            if ((n > FILL_W'(k)) && (r_rank_rd[k] > r_rank_rd[victim])) begin
                victim = WAY_W'(k);
            end
        end

        if (hit) begin
            tgt = hit_way;
        end else if (free) begin
            tgt = WAY_W'(fill);
        end else begin
            tgt = victim;
        end
        tgt_rank = r_rank_rd[tgt];

        n_tags  = r_tag_rd;
        n_ranks = r_rank_rd;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (WAY_W'(k) == tgt) begin
                n_ranks[k] = '0;
                if (!hit) begin
                    n_tags[k] = r_cur_tag;
                end
            end else if ((n > FILL_W'(k)) && (r_rank_rd[k] < RANK_MAX)
                         && ((!hit && free) || (r_rank_rd[k] < tgt_rank))) begin
                n_ranks[k] = r_rank_rd[k] + RANK_W'(1);
            end
        end

        n_fill = (!hit && free) ? fill + FILL_W'(1) : fill;

        if (hit) begin
            n_outcome = OUT_HIT;
        end else if (free) begin
            n_outcome = OUT_MISS;
        end else begin
            n_outcome = OUT_EVICT;
        end

        modify  = (r_cur_mode == MODE_MODIFY);
        hit_amt = {1'b0, hit} + {1'b0, modify};
        hsum    = {1'b0, r_hits} + (COUNT_BITS+1)'(hit_amt);
        n_hits  = (hsum > {1'b0, CNT_MAX}) ? CNT_MAX : hsum[COUNT_BITS-1:0];

        n_misses = r_misses;
        if (!hit && (r_misses != CNT_MAX)) begin
            n_misses = r_misses + COUNT_BITS'(1);
        end
        n_evicts = r_evicts;
        if (!hit && !free && (r_evicts != CNT_MAX)) begin
            n_evicts = r_evicts + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_tag_rd   <= r_tag_mem[i_q_set];
            r_rank_rd  <= r_rank_mem[i_q_set];
            r_fill_rd  <= r_fill_mem[i_q_set];
            r_vld_rd   <= r_set_vld[i_q_set];
            r_cur_mode <= i_q_mode;
            r_cur_tag  <= i_q_tag;
            r_cur_set  <= i_q_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_tag_mem[r_cur_set]  <= n_tags;
            r_rank_mem[r_cur_set] <= n_ranks;
            r_fill_mem[r_cur_set] <= n_fill;
            r_outcome             <= n_outcome;
            r_store_hit           <= (r_cur_mode == MODE_MODIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_set_vld <= '0;
            r_out_vld <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (commit) begin
                r_set_vld[r_cur_set] <= 1'b1;
                r_hits               <= n_hits;
                r_misses             <= n_misses;
                r_evicts             <= n_evicts;
                r_out_vld            <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_outcome   = r_outcome;
    assign o_store_hit = r_store_hit;
    assign o_hits      = r_hits;
    assign o_misses    = r_misses;
    assign o_evicts    = r_evicts;

endmodule

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// Channel   Direction  Handshake                  Payload
// access    in         i_valid / o_ready          i_mode, i_address
// result    out        o_valid / i_ready          o_outcome, o_store_hit, o_*_count
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One result per access transaction.
// The back end completes the read-modify-write of one set row (tags, ranks, fill
// count) in its memories before it pops the next transaction from the queue.
// Reset clears per-set fill valid bits at once; no clearing pass is needed.
// A 2-entry queue separates classification from lookup; a stalled result holds
// the back end while the front keeps accepting until the queue fills.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_outcome,
    output logic                 o_store_hit,
    output logic [CNT_OUT_W-1:0] o_hit_count,
    output logic [CNT_OUT_W-1:0] o_miss_count,
    output logic [CNT_OUT_W-1:0] o_eviction_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    t_cfg r_cfg;

    logic                  q_vld, q_pop;
    logic [1:0]            q_mode;
    logic [TAG_W-1:0]      q_tag;
    logic [SET_W-1:0]      q_set;
    logic [COUNT_BITS-1:0] hits, misses, evicts;
    logic [63:0]           hits_w, misses_w, evicts_w;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= RST_SET_BITS;
            r_cfg.ways_in_use <= RST_WAYS;
            r_cfg.block_bits  <= RST_BLOCK_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_cfg.set_bits    <= i_cfg_data[2:0];
                CFG_WAYS:       r_cfg.ways_in_use <= i_cfg_data[3:0];
                CFG_BLOCK_BITS: r_cfg.block_bits  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    salc_front #(
        .MAX_SET_BITS(MAX_SET_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_address (i_address),
        .o_q_vld   (q_vld),
        .i_q_pop   (q_pop),
        .o_q_mode  (q_mode),
        .o_q_tag   (q_tag),
        .o_q_set   (q_set)
    );

    salc_back #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_vld     (q_vld),
        .o_q_pop     (q_pop),
        .i_q_mode    (q_mode),
        .i_q_tag     (q_tag),
        .i_q_set     (q_set),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_outcome   (o_outcome),
        .o_store_hit (o_store_hit),
        .o_hits      (hits),
        .o_misses    (misses),
        .o_evicts    (evicts)
    );

    assign hits_w           = 64'(hits);
    assign misses_w         = 64'(misses);
    assign evicts_w         = 64'(evicts);
    assign o_hit_count      = hits_w[CNT_OUT_W-1:0];
    assign o_miss_count     = misses_w[CNT_OUT_W-1:0];
    assign o_eviction_count = evicts_w[CNT_OUT_W-1:0];

endmodule

// ===== dv/salc_lookup_checker.sv =====
`timescale 1ns / 100ps
module salc_lookup_checker import salc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc_valid,
    input  logic                 i_acc_ready,
    input  logic [1:0]           i_mode,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [1:0]           i_outcome,
    input  logic                 i_store_hit,
    input  logic [CNT_OUT_W-1:0] i_hit_count,
    input  logic [CNT_OUT_W-1:0] i_miss_count,
    input  logic [CNT_OUT_W-1:0] i_eviction_count,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_checked,
    output int                   o_failures
);

    localparam int NUM_SETS  = 1 << DEF_MAX_SET_BITS;
    localparam int NUM_SLOTS = NUM_SETS * DEF_MAX_WAYS;
    localparam logic [2:0] RANK_MAX = 3'(DEF_MAX_WAYS - 1);

    typedef struct packed {
        logic [1:0]           outcome;
        logic                 store_hit;
        logic [CNT_OUT_W-1:0] hits;
        logic [CNT_OUT_W-1:0] misses;
        logic [CNT_OUT_W-1:0] evictions;
    } t_lookup;

    logic [TAG_W-1:0]     way_tag  [NUM_SLOTS];
    logic [2:0]           way_rank [NUM_SLOTS];
    logic [3:0]           set_fill [NUM_SETS];
    logic [CNT_OUT_W-1:0] hit_total;
    logic [CNT_OUT_W-1:0] miss_total;
    logic [CNT_OUT_W-1:0] evict_total;
    t_cfg                 cfg;
    t_lookup              pending_lookups [$];
    int                   checked_n;
    int                   fail_n;

    initial begin
        checked_n  = 0;
        fail_n     = 0;
        o_checked  = 0;
        o_failures = 0;
    end

    function automatic logic [CNT_OUT_W-1:0] sat_inc(logic [CNT_OUT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // way w becomes most recent among the first n ways of the set
    function automatic void promote(int base, int n, int w);
        logic [2:0] r;
        r = way_rank[base + w];
        for (int k = 0; k < n; k++) begin
            if (k != w && way_rank[base + k] < r && way_rank[base + k] < RANK_MAX)
                way_rank[base + k]++;
        end
        way_rank[base + w] = '0;
    endfunction

    function automatic t_lookup lookup_access(logic [1:0] mode, logic [ADDR_W-1:0] addr);
        t_lookup          r;
        int               s;
        int               e;
        int               b;
        int               set_idx;
        int               base;
        int               fill;
        int               n;
        int               hit_way;
        int               victim;
        logic [TAG_W-1:0] tag;
        s = (cfg.set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg.set_bits);
        if (cfg.ways_in_use == 0)
            e = 1;
        else if (cfg.ways_in_use > DEF_MAX_WAYS)
            e = DEF_MAX_WAYS;
        else
            e = int'(cfg.ways_in_use);
        b = int'(cfg.block_bits);
        tag = (s + b < 64) ? (addr >> (s + b)) : '0;
        set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
        base = set_idx * DEF_MAX_WAYS;
        fill = int'(set_fill[set_idx]);
        n = (fill < e) ? fill : e;
        hit_way = -1;
        for (int k = 0; k < n; k++) begin
            if (hit_way < 0 && way_tag[base + k] == tag)
                hit_way = k;
        end
        if (hit_way >= 0) begin
            promote(base, n, hit_way);
            hit_total = sat_inc(hit_total);
            r.outcome = OUT_HIT;
        end else if (fill < e) begin
            for (int k = 0; k < n; k++) begin
                if (way_rank[base + k] < RANK_MAX)
                    way_rank[base + k]++;
            end
            way_tag[base + fill]  = tag;
            way_rank[base + fill] = '0;
            set_fill[set_idx]     = 4'(fill + 1);
            miss_total = sat_inc(miss_total);
            r.outcome = OUT_MISS;
        end else begin
            victim = 0;
            for (int k = 1; k < n; k++) begin
                if (way_rank[base + k] > way_rank[base + victim])
                    victim = k;
            end
            way_tag[base + victim] = tag;
            promote(base, n, victim);
            miss_total  = sat_inc(miss_total);
            evict_total = sat_inc(evict_total);
            r.outcome = OUT_EVICT;
        end
        // modify adds a store that always hits
        if (mode == MODE_MODIFY)
            hit_total = sat_inc(hit_total);
        r.store_hit = (mode == MODE_MODIFY);
        r.hits      = hit_total;
        r.misses    = miss_total;
        r.evictions = evict_total;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup want;
        t_lookup got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SETS; i++)
                set_fill[i] = '0;
            hit_total   = '0;
            miss_total  = '0;
            evict_total = '0;
            cfg.set_bits    = RST_SET_BITS;
            cfg.ways_in_use = RST_WAYS;
            cfg.block_bits  = RST_BLOCK_BITS;
            pending_lookups.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = '{i_outcome, i_store_hit, i_hit_count, i_miss_count, i_eviction_count};
                if (pending_lookups.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10) begin
                        $write("ERROR: unexpected result: outcome %0d store_hit %0b",
                               got.outcome, got.store_hit);
                        $display(" hits %0d misses %0d evictions %0d",
                                 got.hits, got.misses, got.evictions);
                    end
                end else begin
                    want = pending_lookups.pop_front();
                    checked_n++;
                    if (got !== want) begin
                        fail_n++;
                        if (fail_n <= 10) begin
                            $write("ERROR: access %0d: expected outcome %0d store_hit %0b",
                                   checked_n, want.outcome, want.store_hit);
                            $display(" hits %0d misses %0d evictions %0d",
                                     want.hits, want.misses, want.evictions);
                            $write("       actual outcome %0d store_hit %0b",
                                   got.outcome, got.store_hit);
                            $display(" hits %0d misses %0d evictions %0d",
                                     got.hits, got.misses, got.evictions);
                        end
                    end
                end
            end
            if (i_acc_valid && i_acc_ready)
                pending_lookups.push_back(lookup_access(i_mode, i_address));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   cfg.set_bits    = i_cfg_data[2:0];
                    CFG_WAYS:       cfg.ways_in_use = i_cfg_data[3:0];
                    CFG_BLOCK_BITS: cfg.block_bits  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_checked  <= checked_n;
        o_failures <= fail_n;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import salc_pkg::*;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_RSVD  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int FIXED_PHASES    = 12;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int MAX_GAP         = 12;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [1:0]           i_mode      = '0;
    logic [ADDR_W-1:0]    i_address   = '0;
    logic                 i_ready     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [1:0]           o_outcome;
    logic                 o_store_hit;
    logic [CNT_OUT_W-1:0] o_hit_count;
    logic [CNT_OUT_W-1:0] o_miss_count;
    logic [CNT_OUT_W-1:0] o_eviction_count;
    logic                 o_cfg_ready;

    int          checked;
    int          failures;
    int          sent       = 0;
    int          settings_n = 1;
    int          send_left  = 0;
    int          recv_left  = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    logic [63:0] tag_pool [10];
    int          hot_sets   = 1;
    int          eff_sets   = 4;
    int          eff_ways   = 1;
    int          blk        = 4;

    int phase_set   [FIXED_PHASES] = '{4, 6, 0, 3, 3, 3, 7, 0, 6, 5, 2, 1};
    int phase_ways  [FIXED_PHASES] = '{1, 8, 8, 8, 3, 8, 15, 1, 2, 9, 0, 4};
    int phase_block [FIXED_PHASES] = '{4, 0, 6, 5, 5, 5, 63, 0, 32, 58, 62, 42};

    set_assoc_lru_cache_sim DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_outcome        (o_outcome),
        .o_store_hit      (o_store_hit),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    salc_lookup_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_acc_valid      (i_valid),
        .i_acc_ready      (o_ready),
        .i_mode           (i_mode),
        .i_address        (i_address),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_outcome        (o_outcome),
        .i_store_hit      (o_store_hit),
        .i_hit_count      (o_hit_count),
        .i_miss_count     (o_miss_count),
        .i_eviction_count (o_eviction_count),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_checked        (checked),
        .o_failures       (failures)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // stretches of random gaps alternate with stretches of none
    function automatic int draw_gap(inout int left, inout bit quiet);
        if (left == 0) begin
            left  = $urandom_range(8, 64);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_access(logic [1:0] mode, logic [63:0] addr);
        int gap;
        gap = draw_gap(send_left, send_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_address <= addr;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_cache(int set_b, int ways, int block, bit poke_spare);
        write_reg(CFG_SET_BITS, 6'(set_b));
        write_reg(CFG_WAYS, 6'(ways));
        write_reg(CFG_BLOCK_BITS, 6'(block));
        if (poke_spare)
            write_reg(CFG_SPARE, 6'($urandom));
        i_cfg_valid <= 1'b0;
        eff_sets = (set_b > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_b;
        eff_ways = (ways == 0) ? 1 : (ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways;
        blk = block;
        settings_n++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (checked != sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly addresses from a small hot working set, some full-width noise
    function automatic logic [63:0] pick_address();
        logic [63:0] tag;
        logic [63:0] setv;
        logic [63:0] off;
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        tag  = tag_pool[$urandom_range(0, eff_ways + 1)];
        setv = 64'($urandom_range(0, hot_sets - 1));
        off  = {$urandom, $urandom};
        return (tag << (eff_sets + blk)) | (setv << blk) | (off & ((64'd1 << blk) - 64'd1));
    endfunction

    initial begin : receiver
        int gap;
        @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_left, recv_quiet);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int s_cfg;
        int w_cfg;
        int b_cfg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 16 sets, direct mapped, 16-byte blocks
        send_access(MODE_LOAD, 64'h0);
        send_access(MODE_LOAD, 64'h8);
        send_access(MODE_STORE, 64'h0);
        send_access(MODE_MODIFY, 64'h0);
        send_access(MODE_LOAD, 64'h100);
        send_access(MODE_MODIFY, 64'h0);
        send_access(MODE_RSVD, 64'h0);
        send_access(MODE_LOAD, '1);
        send_access(MODE_STORE, '1);
        send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
        wait_idle();

        // oversized set bits, zero ways, offset covering nearly the whole address
        program_cache(7, 0, 63, 1'b1);
        send_access(MODE_LOAD, 64'h0);
        send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
        send_access(MODE_MODIFY, '1);
        send_access(MODE_RSVD, 64'h7fff_ffff_ffff_ffff);
        send_access(MODE_STORE, 64'h1);
        wait_idle();

        // all sets, oversized ways, no offset: fill set 0 then evict
        program_cache(6, 15, 0, 1'b0);
        send_access(MODE_STORE, 64'h3f);
        for (int k = 0; k < 9; k++)
            send_access(MODE_LOAD, 64'(k) << 6);
        send_access(MODE_MODIFY, 64'h0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p < FIXED_PHASES) begin
                s_cfg = phase_set[p];
                w_cfg = phase_ways[p];
                b_cfg = phase_block[p];
            end else begin
                s_cfg = $urandom_range(0, 7);
                w_cfg = $urandom_range(0, 15);
                b_cfg = $urandom_range(0, 63);
            end
            program_cache(s_cfg, w_cfg, b_cfg, p == PHASES - 1);
            hot_sets = $urandom_range(1, 4);
            if (hot_sets > (1 << eff_sets))
                hot_sets = 1 << eff_sets;
            for (int i = 0; i < 10; i++)
                tag_pool[i] = {$urandom, $urandom};
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_access(2'($urandom_range(0, 3)), pick_address());
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Checked %0d cache accesses over %0d cache settings, all four access modes.",
                 checked, settings_n);
        $display("Settings spanned 0 to 7 set bits, 0 to 15 ways and 0 to 63 offset bits.");
        if (failures == 0)
            $display("set_assoc_lru_cache_sim test passed");
        else
            $display("set_assoc_lru_cache_sim test failed");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("set_assoc_lru_cache_sim test failed");
        $finish;
    end

endmodule
